// ===== rtl/core/ura_pkg.sv =====
// shared types and constants for the ultrasonic ranger with moving average
package ura_pkg;

  localparam int WINDOW_DEF = 10;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 18;
  localparam int DUR_W = 16;
  localparam int TMR_W = 18;
  localparam int SCALE_W = 18;
  localparam int PW_W = 16;
  localparam int DIST_W = 17;
  localparam int PROD_W = PW_W + SCALE_W;

  localparam logic [DUR_W-1:0] TRIG_LOW_RST = 16'd2000;
  localparam logic [DUR_W-1:0] TRIG_HIGH_RST = 16'd10000;
  localparam logic [DUR_W-1:0] LISTEN_TO_RST = 16'd30000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 18'd112394;
  localparam logic [TMR_W-1:0] GAP_RST = 18'd200000;

  localparam logic [PW_W-1:0] PW_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIG_LOW  = 3'd0,
    REG_TRIG_HIGH = 3'd1,
    REG_LISTEN_TO = 3'd2,
    REG_SCALE     = 3'd3,
    REG_GAP       = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_GAP    = 3'd0,
    PH_TLOW   = 3'd1,
    PH_THIGH  = 3'd2,
    PH_LISTEN = 3'd3,
    PH_ECHO   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MUL  = 3'd1,
    ST_SUM  = 3'd2,
    ST_DIV  = 3'd3,
    ST_DONE = 3'd4
  } seq_t;

endpackage

// ===== rtl/core/ultrasonic_ranger_with_average.sv =====
// ultrasonic echo ranger with trigger sequencing and a moving-average window
// One item is one microsecond tick: it carries the sampled echo level in and returns exactly one
// result with the trigger level for that tick. A tick that ends a measurement (echo fall or listen
// timeout) goes through a multiply step, a walk through the sample memory one entry per cycle over
// the window entries in use, and a restoring divide one quotient bit per cycle over SUM_W bits,
// where SUM_W is 17 + clog2(WINDOW); the walk and the divide both run on the same adder.
// The block takes no tick while it works on one.
module ultrasonic_ranger_with_average #(
  parameter int WINDOW = ura_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           echo_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           trigger_level,
  output logic                           result_valid,
  output logic [ura_pkg::DIST_W-1:0]     distance,
  output logic [ura_pkg::DIST_W-1:0]     average,
  output logic                           timed_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ura_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = ura_pkg::DIST_W + $clog2(WINDOW);
  localparam int DCNT_W = $clog2(SUM_W + 1);

  // configuration
  logic [ura_pkg::DUR_W-1:0]   trigger_low_us;
  logic [ura_pkg::DUR_W-1:0]   trigger_high_us;
  logic [ura_pkg::DUR_W-1:0]   listen_timeout_us;
  logic [ura_pkg::SCALE_W-1:0] scale_q16;
  logic [ura_pkg::TMR_W-1:0]   gap_us;

  // tick state
  ura_pkg::phase_t             phase, phase_next;
  logic [ura_pkg::TMR_W-1:0]   phase_timer, phase_timer_next;
  logic [ura_pkg::PW_W-1:0]    pulse_width, pulse_width_next;
  logic                        trig_tick;
  logic                        fin;
  logic                        fin_timeout;
  logic                        pend_timeout;

  // sequencer and datapath
  ura_pkg::seq_t               seq, seq_next;
  logic [IDX_W-1:0]            write_index;
  logic [CNT_W-1:0]            fill_count;
  logic [CNT_W-1:0]            sum_cnt;
  logic [DCNT_W-1:0]           div_cnt;
  logic                        rvalid;
  logic [SUM_W-1:0]            acc;
  logic [CNT_W-1:0]            rem;
  logic [ura_pkg::DIST_W-1:0]  store [WINDOW];
  logic [ura_pkg::DIST_W-1:0]  rdata;
  logic [IDX_W-1:0]            raddr;
  logic                        mem_we;
  logic [ura_pkg::PROD_W-1:0]  prod;
  logic [ura_pkg::DIST_W-1:0]  dist_calc;
  logic [SUM_W:0]              alu_a, alu_b, alu_y;
  logic                        alu_sub;
  logic [CNT_W:0]              div_shift;
  logic                        q_bit;
  logic                        in_accept;
  logic                        slot_free;
  logic                        load_tick;
  logic                        load_done;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // per-tick phase logic
  always_comb begin
    ura_pkg::phase_t           ph_eff;
    logic [ura_pkg::TMR_W-1:0] tmr_eff;
    logic [ura_pkg::TMR_W-1:0] tmr_inc;
    logic [ura_pkg::DUR_W-1:0] lo_thr;
    logic [ura_pkg::DUR_W-1:0] hi_thr;
    logic [ura_pkg::DUR_W-1:0] to_thr;
    lo_thr = (trigger_low_us == '0) ? ura_pkg::DUR_W'(1) : trigger_low_us;
    hi_thr = (trigger_high_us == '0) ? ura_pkg::DUR_W'(1) : trigger_high_us;
    to_thr = (listen_timeout_us == '0) ? ura_pkg::DUR_W'(1) : listen_timeout_us;
    ph_eff = phase;
    tmr_eff = phase_timer;
    if (phase == ura_pkg::PH_GAP && phase_timer >= gap_us) begin
      ph_eff = ura_pkg::PH_TLOW;
      tmr_eff = '0;
    end
    tmr_inc = tmr_eff + 1'b1;
    phase_next = ph_eff;
    phase_timer_next = tmr_inc;
    pulse_width_next = pulse_width;
    trig_tick = 1'b0;
    fin = 1'b0;
    fin_timeout = 1'b0;
    unique case (ph_eff)
      ura_pkg::PH_GAP: begin
      end
      ura_pkg::PH_TLOW: begin
        if (tmr_inc >= ura_pkg::TMR_W'(lo_thr)) begin
          phase_next = ura_pkg::PH_THIGH;
          phase_timer_next = '0;
        end
      end
      ura_pkg::PH_THIGH: begin
        trig_tick = 1'b1;
        if (tmr_inc >= ura_pkg::TMR_W'(hi_thr)) begin
          phase_next = ura_pkg::PH_LISTEN;
          phase_timer_next = '0;
        end
      end
      ura_pkg::PH_LISTEN: begin
        if (echo_level) begin
          phase_next = ura_pkg::PH_ECHO;
          phase_timer_next = '0;
          pulse_width_next = ura_pkg::PW_W'(1);
        end else if (tmr_inc >= ura_pkg::TMR_W'(to_thr)) begin
          fin = 1'b1;
          fin_timeout = 1'b1;
          phase_next = ura_pkg::PH_GAP;
          phase_timer_next = '0;
        end
      end
      ura_pkg::PH_ECHO: begin
        phase_timer_next = tmr_eff;
        if (echo_level) begin
          if (pulse_width != ura_pkg::PW_MAX) begin
            pulse_width_next = pulse_width + 1'b1;
          end
        end else begin
          // width is kept for the multiply and cleared there
          fin = 1'b1;
          phase_next = ura_pkg::PH_GAP;
          phase_timer_next = '0;
        end
      end
      default: begin
        phase_next = ura_pkg::PH_GAP;
        phase_timer_next = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      ura_pkg::ST_IDLE: if (in_accept && fin) seq_next = ura_pkg::ST_MUL;
      ura_pkg::ST_MUL:  seq_next = ura_pkg::ST_SUM;
      ura_pkg::ST_SUM:  if (sum_cnt == fill_count) seq_next = ura_pkg::ST_DIV;
      ura_pkg::ST_DIV:  if (div_cnt == DCNT_W'(SUM_W - 1)) seq_next = ura_pkg::ST_DONE;
      ura_pkg::ST_DONE: if (slot_free) seq_next = ura_pkg::ST_IDLE;
      default:          seq_next = ura_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we = 1'b0;
    load_done = 1'b0;
    unique case (seq)
      ura_pkg::ST_IDLE: in_ready = slot_free;
      ura_pkg::ST_MUL:  mem_we = 1'b1;
      ura_pkg::ST_SUM:  ;
      ura_pkg::ST_DIV:  ;
      ura_pkg::ST_DONE: load_done = slot_free;
      default:          ;
    endcase
  end

  assign load_tick = in_accept && !fin;

  // distance from echo width, saturating; zero on a listen timeout
  assign prod = ura_pkg::PROD_W'(pulse_width) * ura_pkg::PROD_W'(scale_q16);
  always_comb begin
    if (pend_timeout) begin
      dist_calc = '0;
    end else if (prod[ura_pkg::PROD_W-1]) begin
      dist_calc = ura_pkg::DIST_MAX;
    end else begin
      dist_calc = prod[ura_pkg::PROD_W-2:16];
    end
  end

  assign raddr = (sum_cnt < fill_count) ? sum_cnt[IDX_W-1:0] : '0;

  // shared adder: accumulate during the window walk, trial subtract during the divide
  assign div_shift = {rem, acc[SUM_W-1]};
  always_comb begin
    alu_a = {1'b0, acc};
    alu_b = (SUM_W + 1)'(rdata);
    alu_sub = 1'b0;
    if (seq == ura_pkg::ST_DIV) begin
      alu_a = (SUM_W + 1)'(div_shift);
      alu_b = (SUM_W + 1)'(fill_count);
      alu_sub = 1'b1;
    end
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end
  assign q_bit = !alu_y[SUM_W];

  // sample memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[write_index] <= dist_calc;
    end
    rdata <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_low_us <= ura_pkg::TRIG_LOW_RST;
      trigger_high_us <= ura_pkg::TRIG_HIGH_RST;
      listen_timeout_us <= ura_pkg::LISTEN_TO_RST;
      scale_q16 <= ura_pkg::SCALE_RST;
      gap_us <= ura_pkg::GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ura_pkg::REG_TRIG_LOW:  trigger_low_us <= cfg_data[ura_pkg::DUR_W-1:0];
        ura_pkg::REG_TRIG_HIGH: trigger_high_us <= cfg_data[ura_pkg::DUR_W-1:0];
        ura_pkg::REG_LISTEN_TO: listen_timeout_us <= cfg_data[ura_pkg::DUR_W-1:0];
        ura_pkg::REG_SCALE:     scale_q16 <= cfg_data;
        ura_pkg::REG_GAP:       gap_us <= cfg_data;
        default:                ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= ura_pkg::ST_IDLE;
      phase <= ura_pkg::PH_GAP;
      phase_timer <= '0;
      pulse_width <= '0;
      write_index <= '0;
      fill_count <= '0;
      sum_cnt <= '0;
      div_cnt <= '0;
      rvalid <= 1'b0;
      pend_timeout <= 1'b0;
      out_valid <= 1'b0;
      trigger_level <= 1'b0;
      result_valid <= 1'b0;
      distance <= '0;
      average <= '0;
      timed_out <= 1'b0;
    end else begin
      seq <= seq_next;
      rvalid <= (seq == ura_pkg::ST_SUM) && (sum_cnt < fill_count);

      if (in_accept) begin
        phase <= phase_next;
        phase_timer <= phase_timer_next;
        pulse_width <= pulse_width_next;
        pend_timeout <= fin_timeout;
      end

      if (seq == ura_pkg::ST_MUL) begin
        pulse_width <= '0;
        distance <= dist_calc;
        timed_out <= pend_timeout;
        write_index <= (write_index == IDX_W'(WINDOW - 1)) ? '0 : write_index + 1'b1;
        if (fill_count < CNT_W'(WINDOW)) begin
          fill_count <= fill_count + 1'b1;
        end
        sum_cnt <= '0;
        div_cnt <= '0;
      end

      if (seq == ura_pkg::ST_SUM) begin
        sum_cnt <= sum_cnt + 1'b1;
      end
      if (seq == ura_pkg::ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end

      if (load_tick) begin
        out_valid <= 1'b1;
        trigger_level <= trig_tick;
        result_valid <= 1'b0;
      end else if (load_done) begin
        out_valid <= 1'b1;
        trigger_level <= 1'b0;
        result_valid <= 1'b1;
        average <= acc[ura_pkg::DIST_W-1:0];
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // accumulator and remainder, no reset needed
  always_ff @(posedge clk) begin
    if (seq == ura_pkg::ST_MUL) begin
      acc <= '0;
      rem <= '0;
    end else if (seq == ura_pkg::ST_SUM) begin
      if (rvalid) begin
        acc <= alu_y[SUM_W-1:0];
      end
    end else if (seq == ura_pkg::ST_DIV) begin
      rem <= q_bit ? alu_y[CNT_W-1:0] : div_shift[CNT_W-1:0];
      acc <= {acc[SUM_W-2:0], q_bit};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW) && write_index <= IDX_W'(WINDOW - 1))
    else $error("window bookkeeping out of range");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (seq == ura_pkg::ST_DIV) |-> (rem < fill_count))
    else $error("divider remainder not below divisor");

  a_mul_to_sum: assert property (@(posedge clk) disable iff (rst)
    (seq == ura_pkg::ST_MUL) |=> (seq == ura_pkg::ST_SUM && fill_count != '0))
    else $error("multiply step not followed by window walk");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    timed_out |-> (distance == '0))
    else $error("timed-out measurement with nonzero distance");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (seq != ura_pkg::ST_IDLE) |-> !in_ready)
    else $error("tick taken while measurement in progress");

endmodule
